// File: rtl/core/clrf_pkg.sv
// Package for the clipped rectangle fill byte sequencer.
// Holds widths, panel command codes, header positions, status codes and the
// item structs used by the clipper, the core and the top level.
package clrf_pkg;

  // Default clip limits for the top-level parameters
  localparam int unsigned MAX_WIDTH_DEF  = 480;
  localparam int unsigned MAX_HEIGHT_DEF = 320;

  // Coordinate and pixel count widths
  localparam int unsigned DIM_W = 9;
  localparam int unsigned PIX_W = 2 * DIM_W;

  // Configuration registers
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
  localparam logic [DIM_W-1:0] SCREEN_WIDTH_RST  = 9'd480;
  localparam logic [DIM_W-1:0] SCREEN_HEIGHT_RST = 9'd320;

  // Panel commands
  localparam logic [7:0] CMD_CASET = 8'h2A;
  localparam logic [7:0] CMD_PASET = 8'h2B;
  localparam logic [7:0] CMD_RAMWR = 8'h2C;

  // Header byte positions; HDR_PIXELS marks the pixel phase
  localparam logic [3:0] HDR_CASET  = 4'd0;
  localparam logic [3:0] HDR_XS_HI  = 4'd1;
  localparam logic [3:0] HDR_XS_LO  = 4'd2;
  localparam logic [3:0] HDR_XE_HI  = 4'd3;
  localparam logic [3:0] HDR_XE_LO  = 4'd4;
  localparam logic [3:0] HDR_PASET  = 4'd5;
  localparam logic [3:0] HDR_YS_HI  = 4'd6;
  localparam logic [3:0] HDR_YS_LO  = 4'd7;
  localparam logic [3:0] HDR_YE_HI  = 4'd8;
  localparam logic [3:0] HDR_YE_LO  = 4'd9;
  localparam logic [3:0] HDR_RAMWR  = 4'd10;
  localparam logic [3:0] HDR_PIXELS = 4'd11;

  // Result status codes
  localparam logic [1:0] ST_BYTE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_IDLE  = 2'd2;

  // Request actions
  localparam logic ACT_START   = 1'b0;
  localparam logic ACT_ADVANCE = 1'b1;

  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } chan_e;

  typedef struct packed {
    logic               action;
    logic signed [15:0] rect_x;
    logic signed [15:0] rect_y;
    logic signed [15:0] rect_w;
    logic signed [15:0] rect_h;
    logic [15:0]        fill_color;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       data_not_command;
    logic       frame_end;
    logic       last;
    logic [1:0] status;
  } out_item_t;

  // Clipped rectangle handed from the clipper to the sequencer core
  typedef struct packed {
    logic             empty;
    logic [DIM_W-1:0] col_start;
    logic [DIM_W-1:0] col_end;
    logic [DIM_W-1:0] row_start;
    logic [DIM_W-1:0] row_end;
    logic [PIX_W-1:0] pixels;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
  } fill_t;

endpackage

// File: rtl/core/clrf_if.sv
// Valid/ready channel interfaces of the fill sequencer: request, byte and
// configuration write channels. Depends on clrf_pkg for widths.
interface clrf_req_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [15:0] rect_x;
  logic signed [15:0] rect_y;
  logic signed [15:0] rect_w;
  logic signed [15:0] rect_h;
  logic [15:0]        fill_color;

  modport source (output valid, action, rect_x, rect_y, rect_w, rect_h, fill_color,
                  input ready);
  modport sink   (input valid, action, rect_x, rect_y, rect_w, rect_h, fill_color,
                  output ready);
endinterface

interface clrf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       data_not_command;
  logic       frame_end;
  logic       last;
  logic [1:0] status;

  modport source (output valid, out_byte, data_not_command, frame_end, last, status,
                  input ready);
  modport sink   (input valid, out_byte, data_not_command, frame_end, last, status,
                  output ready);
endinterface

interface clrf_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [clrf_pkg::CFG_IDX_W-1:0]   index;
  logic [clrf_pkg::DIM_W-1:0]       wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

// File: rtl/core/clrf_clip.sv
// Rectangle clipper: clips a signed fill request to the visible screen and
// expands the RGB565 colour. Purely combinational; depends on clrf_pkg.
module clrf_clip #(
  parameter int unsigned MAX_WIDTH  = clrf_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = clrf_pkg::MAX_HEIGHT_DEF
) (
  input  clrf_pkg::in_item_t             item_i,
  input  logic [clrf_pkg::DIM_W-1:0]     screen_width_i,
  input  logic [clrf_pkg::DIM_W-1:0]     screen_height_i,
  output clrf_pkg::fill_t                fill_o
);

  localparam logic [12:0] MaxW = 13'(MAX_WIDTH);
  localparam logic [12:0] MaxH = 13'(MAX_HEIGHT);

  logic [clrf_pkg::DIM_W-1:0] sw, sh;
  logic signed [17:0] sw_s, sh_s;
  logic signed [17:0] x_s, y_s, w_s, h_s;
  logic signed [17:0] xa, ya, wa, ha, wb, hb;
  logic               x_off, y_off;

  // Limit the screen size to the build-time maximum
  assign sw   = ({4'b0, screen_width_i} < MaxW) ? screen_width_i : MaxW[8:0];
  assign sh   = ({4'b0, screen_height_i} < MaxH) ? screen_height_i : MaxH[8:0];
  assign sw_s = {9'b0, sw};
  assign sh_s = {9'b0, sh};

  assign x_s = 18'(item_i.rect_x);
  assign y_s = 18'(item_i.rect_y);
  assign w_s = 18'(item_i.rect_w);
  assign h_s = 18'(item_i.rect_h);

  // Drop the part left of or above the screen
  assign xa = x_s[17] ? 18'sd0 : x_s;
  assign ya = y_s[17] ? 18'sd0 : y_s;
  assign wa = x_s[17] ? (w_s + x_s) : w_s;
  assign ha = y_s[17] ? (h_s + y_s) : h_s;

  assign x_off = (xa >= sw_s);
  assign y_off = (ya >= sh_s);

  // Drop the part right of or below the screen
  assign wb = ((xa + wa) > sw_s) ? (sw_s - xa) : wa;
  assign hb = ((ya + ha) > sh_s) ? (sh_s - ya) : ha;

  assign fill_o.empty = (w_s <= 18'sd0) || (h_s <= 18'sd0) || x_off || y_off ||
                        (wb <= 18'sd0) || (hb <= 18'sd0);

  assign fill_o.col_start = xa[8:0];
  assign fill_o.row_start = ya[8:0];
  assign fill_o.col_end   = 9'(xa + wb - 18'sd1);
  assign fill_o.row_end   = 9'(ya + hb - 18'sd1);
  assign fill_o.pixels    = {9'b0, wb[8:0]} * {9'b0, hb[8:0]};

  // Expand RGB565 to one byte per channel
  assign fill_o.red   = {item_i.fill_color[15:11], 3'b000};
  assign fill_o.green = {item_i.fill_color[10:5], 2'b00};
  assign fill_o.blue  = {item_i.fill_color[4:0], 3'b000};

endmodule

// File: rtl/core/clrf_core.sv
// Byte sequencer core: holds the fill state and picks the next panel byte
// or status code for each processed transaction. Depends on clrf_pkg.
module clrf_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  advance_i,
  input  clrf_pkg::in_item_t    item_i,
  input  clrf_pkg::fill_t       fill_i,
  output clrf_pkg::out_item_t   result_o
);

  logic                          busy_q, busy_d;
  logic [3:0]                    hdr_q, hdr_d;
  logic [clrf_pkg::DIM_W-1:0]    col_start_q, col_start_d, col_end_q, col_end_d;
  logic [clrf_pkg::DIM_W-1:0]    row_start_q, row_start_d, row_end_q, row_end_d;
  logic [clrf_pkg::PIX_W-1:0]    pixels_left_q, pixels_left_d;
  clrf_pkg::chan_e               chan_q, chan_d;
  logic [7:0]                    red_q, red_d, green_q, green_d, blue_q, blue_d;
  logic                          fin;

  assign fin = (pixels_left_q <= clrf_pkg::PIX_W'(1));

  // Next state and result for the transaction being processed
  always_comb begin
    busy_d        = busy_q;
    hdr_d         = hdr_q;
    col_start_d   = col_start_q;
    col_end_d     = col_end_q;
    row_start_d   = row_start_q;
    row_end_d     = row_end_q;
    pixels_left_d = pixels_left_q;
    chan_d        = chan_q;
    red_d         = red_q;
    green_d       = green_q;
    blue_d        = blue_q;
    result_o      = '0;
    result_o.status = clrf_pkg::ST_BYTE;

    if (advance_i) begin
      if (item_i.action == clrf_pkg::ACT_START) begin
        busy_d = 1'b0;
        if (fill_i.empty) begin
          result_o.status = clrf_pkg::ST_EMPTY;
        end else begin
          col_start_d   = fill_i.col_start;
          col_end_d     = fill_i.col_end;
          row_start_d   = fill_i.row_start;
          row_end_d     = fill_i.row_end;
          pixels_left_d = fill_i.pixels;
          chan_d        = clrf_pkg::CH_RED;
          red_d         = fill_i.red;
          green_d       = fill_i.green;
          blue_d        = fill_i.blue;
          busy_d        = 1'b1;
          hdr_d         = clrf_pkg::HDR_XS_HI;
          result_o.out_byte = clrf_pkg::CMD_CASET;
        end
      end else if (!busy_q) begin
        result_o.status = clrf_pkg::ST_IDLE;
      end else if (hdr_q < clrf_pkg::HDR_PIXELS) begin
        // Address window header, coordinates big-endian
        result_o.data_not_command = 1'b1;
        case (hdr_q)
          clrf_pkg::HDR_CASET: begin
            result_o.data_not_command = 1'b0;
            result_o.out_byte         = clrf_pkg::CMD_CASET;
          end
          clrf_pkg::HDR_XS_HI: result_o.out_byte = {7'b0, col_start_q[8]};
          clrf_pkg::HDR_XS_LO: result_o.out_byte = col_start_q[7:0];
          clrf_pkg::HDR_XE_HI: result_o.out_byte = {7'b0, col_end_q[8]};
          clrf_pkg::HDR_XE_LO: result_o.out_byte = col_end_q[7:0];
          clrf_pkg::HDR_PASET: begin
            result_o.data_not_command = 1'b0;
            result_o.out_byte         = clrf_pkg::CMD_PASET;
          end
          clrf_pkg::HDR_YS_HI: result_o.out_byte = {7'b0, row_start_q[8]};
          clrf_pkg::HDR_YS_LO: result_o.out_byte = row_start_q[7:0];
          clrf_pkg::HDR_YE_HI: result_o.out_byte = {7'b0, row_end_q[8]};
          clrf_pkg::HDR_YE_LO: result_o.out_byte = row_end_q[7:0];
          clrf_pkg::HDR_RAMWR: begin
            result_o.data_not_command = 1'b0;
            result_o.out_byte         = clrf_pkg::CMD_RAMWR;
            result_o.frame_end        = 1'b1;
          end
          default: begin
            result_o.data_not_command = 1'b0;
            result_o.out_byte         = clrf_pkg::CMD_RAMWR;
          end
        endcase
        hdr_d = hdr_q + 4'd1;
      end else begin
        // Pixel phase: R, G, B per pixel
        result_o.data_not_command = 1'b1;
        case (chan_q)
          clrf_pkg::CH_RED: begin
            result_o.out_byte = red_q;
            chan_d            = clrf_pkg::CH_GREEN;
          end
          clrf_pkg::CH_GREEN: begin
            result_o.out_byte = green_q;
            chan_d            = clrf_pkg::CH_BLUE;
          end
          default: begin
            result_o.out_byte  = blue_q;
            result_o.frame_end = fin;
            result_o.last      = fin;
            chan_d             = clrf_pkg::CH_RED;
            if (fin) begin
              pixels_left_d = '0;
              busy_d        = 1'b0;
              hdr_d         = clrf_pkg::HDR_CASET;
            end else begin
              pixels_left_d = pixels_left_q - clrf_pkg::PIX_W'(1);
            end
          end
        endcase
      end
    end
  end

  // Hold the fill state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q        <= 1'b0;
      hdr_q         <= clrf_pkg::HDR_CASET;
      col_start_q   <= '0;
      col_end_q     <= '0;
      row_start_q   <= '0;
      row_end_q     <= '0;
      pixels_left_q <= '0;
      chan_q        <= clrf_pkg::CH_RED;
      red_q         <= '0;
      green_q       <= '0;
      blue_q        <= '0;
    end else begin
      busy_q        <= busy_d;
      hdr_q         <= hdr_d;
      col_start_q   <= col_start_d;
      col_end_q     <= col_end_d;
      row_start_q   <= row_start_d;
      row_end_q     <= row_end_d;
      pixels_left_q <= pixels_left_d;
      chan_q        <= chan_d;
      red_q         <= red_d;
      green_q       <= green_d;
      blue_q        <= blue_d;
    end
  end

  a_busy_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (hdr_q != clrf_pkg::HDR_CASET) && (hdr_q <= clrf_pkg::HDR_PIXELS))
    else $error("header position out of range during a fill");

  a_busy_pixels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (pixels_left_q != '0))
    else $error("fill in progress with no pixels left");

  a_header_chan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && (hdr_q != clrf_pkg::HDR_PIXELS)) |-> (chan_q == clrf_pkg::CH_RED))
    else $error("colour channel moved before the pixel phase");

endmodule

// File: rtl/core/clipped_rect_fill_byte_sequencer.sv
// Top level of the clipped rectangle fill byte sequencer: input register,
// configuration registers, clipper, sequencer core and output register.
// Depends on clrf_pkg, clrf_if, clrf_clip and clrf_core.
// A request is held in the input register, then processed into the output
// register when there is room, from where it is offered on the byte channel.
// Throughput: one transaction per cycle unless the byte channel stalls, set by
// the input and output registers that are both refilled in the cycle they drain.
// Reset: idle, no fill in progress, screen size 480 x 320.
module clipped_rect_fill_byte_sequencer #(
  parameter int unsigned MAX_WIDTH  = clrf_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = clrf_pkg::MAX_HEIGHT_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  clrf_req_if.sink         req_i,
  clrf_byte_if.source      byte_o,
  clrf_cfg_if.sink         cfg_i
);

  logic                        in_valid_q;
  clrf_pkg::in_item_t          in_q;
  logic                        out_valid_q;
  clrf_pkg::out_item_t         out_q;
  logic [clrf_pkg::DIM_W-1:0]  screen_width_q, screen_height_q;
  logic                        advance, accept;
  clrf_pkg::fill_t             fill;
  clrf_pkg::out_item_t         result;

  // Move the held transaction into the output register when there is room
  assign advance     = in_valid_q && (!out_valid_q || byte_o.ready);
  assign req_i.ready = !in_valid_q || advance;
  assign accept      = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= accept || (in_valid_q && !advance);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q.action     <= req_i.action;
      in_q.rect_x     <= req_i.rect_x;
      in_q.rect_y     <= req_i.rect_y;
      in_q.rect_w     <= req_i.rect_w;
      in_q.rect_h     <= req_i.rect_h;
      in_q.fill_color <= req_i.fill_color;
    end
  end

  // Configuration writes; unknown indexes are ignored
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_width_q  <= clrf_pkg::SCREEN_WIDTH_RST;
      screen_height_q <= clrf_pkg::SCREEN_HEIGHT_RST;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == clrf_pkg::CFG_SCREEN_WIDTH) begin
        screen_width_q <= cfg_i.wdata;
      end
      if (cfg_i.index == clrf_pkg::CFG_SCREEN_HEIGHT) begin
        screen_height_q <= cfg_i.wdata;
      end
    end
  end

  clrf_clip #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_clip (
    .item_i          (in_q),
    .screen_width_i  (screen_width_q),
    .screen_height_i (screen_height_q),
    .fill_o          (fill)
  );

  clrf_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (in_q),
    .fill_i    (fill),
    .result_o  (result)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= advance || (out_valid_q && !byte_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign byte_o.valid            = out_valid_q;
  assign byte_o.out_byte         = out_q.out_byte;
  assign byte_o.data_not_command = out_q.data_not_command;
  assign byte_o.frame_end        = out_q.frame_end;
  assign byte_o.last             = out_q.last;
  assign byte_o.status           = out_q.status;

  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed transaction did not reach the output register");

  a_last_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.last) |-> (out_q.frame_end && out_q.data_not_command &&
                                     (out_q.status == clrf_pkg::ST_BYTE)))
    else $error("final byte does not close a data frame");

  a_status_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.status != clrf_pkg::ST_BYTE)) |->
      ((out_q.out_byte == 8'h00) && !out_q.frame_end && !out_q.data_not_command))
    else $error("status result carries a byte");

endmodule
